// File: rtl/core/team_grouped_fifo_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Team queue assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEAM_GROUPED_FIFO_QUEUE_TOP_DEFINES_SVH
`define TEAM_GROUPED_FIFO_QUEUE_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TGFQ_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TGFQ_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked after a delay from the antecedent.
`define TGFQ_CHECK_LATER(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tgfq_pkg.sv
// ----------------------------------------------------------------------------
// Team queue package
// Fixed port widths, command and status codes, controller states.
// ----------------------------------------------------------------------------
package tgfq_pkg;

  localparam int IN_ID_W   = 20;
  localparam int TEAM_IN_W = 10;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ENQ_TEAM,
    S_ENQ_LINK,
    S_ENQ_JOIN,
    S_DEQ_TEAM,
    S_DEQ_POOL
  } state_t;

endpackage

// File: rtl/core/tgfq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tgfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tgfq_team_reduce.sv
// ----------------------------------------------------------------------------
// Team number reduction
// Folds the incoming team number modulo TEAMS by reciprocal multiply.
// Quotient is registered on load; the remainder is valid the next cycle.
// ----------------------------------------------------------------------------
module tgfq_team_reduce import tgfq_pkg::*; #(
  parameter int TEAMS = 1024
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [TEAM_IN_W-1:0]      team_in,
  output logic [$clog2(TEAMS)-1:0]  team_idx
);

  localparam int TW      = $clog2(TEAMS);
  localparam int SH      = TEAM_IN_W + TW;
  localparam int RECIP   = (2 ** SH + TEAMS - 1) / TEAMS;
  localparam int RECIP_W = TEAM_IN_W + 2;
  localparam int PW      = TEAM_IN_W + RECIP_W;
  localparam int PRW     = TEAM_IN_W + TW + 1;

  logic [TEAM_IN_W-1:0] raw;
  logic [TEAM_IN_W-1:0] quot;
  logic [PW-1:0]        prod;
  logic [PRW-1:0]       back;
  logic [PRW-1:0]       diff;

  // exact floor division for any 10-bit numerator
  assign prod = PW'(team_in) * PW'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    if (load) begin
      raw  <= team_in;
      quot <= TEAM_IN_W'(prod >> SH);
    end
  end

  assign back     = PRW'(quot) * PRW'(TEAMS);
  assign diff     = PRW'(raw) - back;
  assign team_idx = diff[TW-1:0];

endmodule

// File: rtl/core/team_grouped_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// Team queue
// Elements of one team stay together; teams are served in arrival order.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears the team table, one entry a
// cycle. A command is taken when start is high and busy is low. An enqueue
// keeps busy high in S_ENQ_TEAM, S_ENQ_LINK, S_ENQ_JOIN (no S_ENQ_JOIN if the
// pool is full), a dequeue in S_DEQ_TEAM, S_DEQ_POOL (no S_DEQ_POOL if the queue
// is empty), following the chained reads of the team table and pool RAMs. The
// result word is on status and out_id for one cycle, marked by done, in the
// cycle in which busy falls. done cannot be stalled: the receiver must take it.
// ----------------------------------------------------------------------------
`include "team_grouped_fifo_queue_top_defines.svh"

module team_grouped_fifo_queue_top import tgfq_pkg::*; #(
  parameter int TEAMS      = 1024,
  parameter int POOL_SLOTS = 4096,
  parameter int ID_WIDTH   = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [IN_ID_W-1:0]   element_id,
  input  logic [TEAM_IN_W-1:0] team,
  output logic                 done,
  output logic [1:0]           status,
  output logic [IN_ID_W-1:0]   out_id
);

  localparam int TW = $clog2(TEAMS);
  localparam int SW = $clog2(POOL_SLOTS);
  localparam int CW = SW + 1;
  localparam int EW = (ID_WIDTH < IN_ID_W) ? ID_WIDTH : IN_ID_W;

  typedef struct packed {
    logic          nonempty;
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [TW-1:0] succ;
  } team_entry_t;

  typedef struct packed {
    logic [EW-1:0] elem;
    logic [SW-1:0] link;
  } pool_entry_t;

  state_t        state, state_next;
  logic [TW-1:0] clr_idx, clr_idx_next;
  logic [SW-1:0] free_head, free_head_next;
  logic [CW-1:0] fresh, fresh_next;
  logic [CW-1:0] used, used_next;
  logic [TW-1:0] order_head, order_head_next;
  logic [TW-1:0] order_tail, order_tail_next;
  logic          order_valid, order_valid_next;
  logic          done_next;

  status_t       status_q, status_next;
  logic [IN_ID_W-1:0] out_id_q, out_id_next;
  logic [EW-1:0] id_q, id_q_next;
  logic [TW-1:0] t_q, t_q_next;
  logic [SW-1:0] slot_q, slot_q_next;
  logic [SW-1:0] tail_q, tail_q_next;
  logic          new_team_q, new_team_next;
  team_entry_t   tent_q, tent_next;

  logic          team_we;
  logic [TW-1:0] team_waddr, team_raddr;
  team_entry_t   team_wdata, team_rdata;
  logic          pool_we;
  logic [SW-1:0] pool_waddr, pool_raddr;
  pool_entry_t   pool_wdata, pool_rdata;

  logic [TW-1:0] team_idx;
  logic          accept;
  logic          has_free, has_fresh;
  logic [CW-1:0] fresh_pos;
  logic [SW-1:0] enq_slot;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  tgfq_team_reduce #(.TEAMS(TEAMS)) u_reduce (
    .clk      (clk),
    .load     (accept),
    .team_in  (team),
    .team_idx (team_idx)
  );

  tgfq_ram #(.WIDTH($bits(team_entry_t)), .DEPTH(TEAMS)) u_team_ram (
    .clk   (clk),
    .we    (team_we),
    .waddr (team_waddr),
    .wdata (team_wdata),
    .raddr (team_raddr),
    .rdata (team_rdata)
  );

  tgfq_ram #(.WIDTH($bits(pool_entry_t)), .DEPTH(POOL_SLOTS)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  // freed slots exist when the used and never-used counts fall short of the pool
  assign has_free  = ((CW+1)'(used) + (CW+1)'(fresh)) < (CW+1)'(POOL_SLOTS);
  assign has_fresh = (fresh != '0);
  assign fresh_pos = CW'(POOL_SLOTS) - fresh;
  assign enq_slot  = has_free ? free_head : fresh_pos[SW-1:0];

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    free_head_next   = free_head;
    fresh_next       = fresh;
    used_next        = used;
    order_head_next  = order_head;
    order_tail_next  = order_tail;
    order_valid_next = order_valid;
    done_next        = 1'b0;
    status_next      = status_q;
    out_id_next      = '0;
    id_q_next        = id_q;
    t_q_next         = t_q;
    slot_q_next      = slot_q;
    tail_q_next      = tail_q;
    new_team_next    = new_team_q;
    tent_next        = tent_q;

    team_we    = 1'b0;
    team_waddr = t_q;
    team_wdata = team_rdata;
    team_raddr = order_head;
    pool_we    = 1'b0;
    pool_waddr = slot_q;
    pool_wdata = '{elem: id_q, link: '0};
    pool_raddr = free_head;

    unique case (state)
      S_CLEAR: begin
        team_we      = 1'b1;
        team_waddr   = clr_idx;
        team_wdata   = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == TW'(TEAMS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          id_q_next = element_id[EW-1:0];
          if (cmd_t'(cmd) == CMD_DEQ) begin
            state_next = S_DEQ_TEAM;
          end else begin
            state_next = S_ENQ_TEAM;
          end
        end
      end

      S_ENQ_TEAM: begin
        team_raddr = team_idx;
        pool_raddr = free_head;
        t_q_next   = team_idx;
        state_next = S_ENQ_LINK;
      end

      S_ENQ_LINK: begin
        if (!has_free && !has_fresh) begin
          done_next   = 1'b1;
          status_next = STAT_FULL;
          state_next  = S_IDLE;
        end else begin
          if (has_free) begin
            free_head_next = pool_rdata.link;
          end else begin
            fresh_next = fresh - 1'b1;
          end
          used_next   = used + 1'b1;
          slot_q_next = enq_slot;
          pool_we     = 1'b1;
          pool_waddr  = enq_slot;
          pool_wdata  = '{elem: id_q, link: '0};
          team_we     = 1'b1;
          team_waddr  = t_q;
          team_wdata  = team_rdata;
          team_wdata.nonempty = 1'b1;
          team_wdata.tail     = enq_slot;
          if (!team_rdata.nonempty) begin
            team_wdata.head = enq_slot;
          end
          // fetch the old tail element and the last team in order for the join step
          pool_raddr    = team_rdata.tail;
          team_raddr    = order_tail;
          tail_q_next   = team_rdata.tail;
          new_team_next = !team_rdata.nonempty;
          state_next    = S_ENQ_JOIN;
        end
      end

      S_ENQ_JOIN: begin
        done_next   = 1'b1;
        status_next = STAT_ENQ;
        state_next  = S_IDLE;
        if (!new_team_q) begin
          pool_we    = 1'b1;
          pool_waddr = tail_q;
          pool_wdata = '{elem: pool_rdata.elem, link: slot_q};
        end else if (order_valid) begin
          team_we         = 1'b1;
          team_waddr      = order_tail;
          team_wdata      = team_rdata;
          team_wdata.succ = t_q;
          order_tail_next = t_q;
        end else begin
          order_head_next  = t_q;
          order_tail_next  = t_q;
          order_valid_next = 1'b1;
        end
      end

      S_DEQ_TEAM: begin
        tent_next  = team_rdata;
        pool_raddr = team_rdata.head;
        if (!order_valid) begin
          done_next   = 1'b1;
          status_next = STAT_EMPTY;
          state_next  = S_IDLE;
        end else begin
          state_next = S_DEQ_POOL;
        end
      end

      S_DEQ_POOL: begin
        done_next      = 1'b1;
        status_next    = STAT_DEQ;
        out_id_next    = IN_ID_W'(pool_rdata.elem);
        state_next     = S_IDLE;
        // push the slot onto the free list
        pool_we        = 1'b1;
        pool_waddr     = tent_q.head;
        pool_wdata     = '{elem: pool_rdata.elem, link: free_head};
        free_head_next = tent_q.head;
        if (used != '0) begin
          used_next = used - 1'b1;
        end
        team_we    = 1'b1;
        team_waddr = order_head;
        team_wdata = tent_q;
        if (tent_q.head == tent_q.tail) begin
          // last element: drop the team from the order
          team_wdata.nonempty = 1'b0;
          order_head_next     = tent_q.succ;
          if (order_head == order_tail) begin
            order_valid_next = 1'b0;
          end
        end else begin
          team_wdata.head = pool_rdata.link;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      free_head   <= '0;
      fresh       <= CW'(POOL_SLOTS);
      used        <= '0;
      order_head  <= '0;
      order_tail  <= '0;
      order_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      free_head   <= free_head_next;
      fresh       <= fresh_next;
      used        <= used_next;
      order_head  <= order_head_next;
      order_tail  <= order_tail_next;
      order_valid <= order_valid_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q   <= status_next;
    out_id_q   <= out_id_next;
    id_q       <= id_q_next;
    t_q        <= t_q_next;
    slot_q     <= slot_q_next;
    tail_q     <= tail_q_next;
    new_team_q <= new_team_next;
    tent_q     <= tent_next;
  end

  assign status = status_q;
  assign out_id = out_id_q;

  `TGFQ_CHECK_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
  `TGFQ_CHECK_NOW(a_pool_bound, state == S_IDLE, ((CW+1)'(used) + (CW+1)'(fresh)) <= (CW+1)'(POOL_SLOTS), "slot counts exceed pool")
  `TGFQ_CHECK_NOW(a_idle_empty, (state == S_IDLE) && !order_valid, used == '0, "slots held with no team in order")
  `TGFQ_CHECK_NOW(a_zero_id, done && (status_q != STAT_DEQ), out_id == '0, "nonzero id on non-dequeue word")
  `TGFQ_CHECK_LATER(a_deq_empty, accept && (cmd_t'(cmd) == CMD_DEQ) && !order_valid, done && (status_q == STAT_EMPTY), "dequeue on empty queue not reported")

endmodule

// File: tb/sv/tb_team_grouped_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// Team queue testbench
// Drives enqueue and dequeue words through the start/busy handshake and checks
// every done word against a predictor of team ordering, the shared slot pool
// and its free list. Covers empty dequeues, field extremes and teams rejoining.
// ----------------------------------------------------------------------------
module tb_team_grouped_fifo_queue_top;
  import tgfq_pkg::*;

  localparam int TEAM_CNT   = 1024;
  localparam int SLOT_CNT   = 4096;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN_WAIT = 8;

  typedef struct {
    status_t          status;
    logic [19:0]      out_id;
  } queue_word_t;

  // Predicts the team queue word by word and matches done words in order.
  class team_queue_scoreboard;
    int          mismatches;
    queue_word_t expected_q[$];
    bit          team_live[TEAM_CNT];
    logic [11:0] team_first[TEAM_CNT];
    logic [11:0] team_last[TEAM_CNT];
    logic [19:0] slot_id[SLOT_CNT];
    logic [11:0] slot_next[SLOT_CNT];
    logic [9:0]  team_order[TEAM_CNT];
    logic [11:0] free_top;
    int          fresh_cnt;
    int          used_cnt;
    logic [9:0]  order_rd;
    logic [9:0]  order_wr;
    int          order_cnt;

    function new();
      mismatches = 0;
      foreach (team_live[i]) team_live[i] = 1'b0;
      free_top  = '0;
      fresh_cnt = SLOT_CNT;
      used_cnt  = 0;
      order_rd  = '0;
      order_wr  = '0;
      order_cnt = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function queue_word_t predict_word(logic c, logic [19:0] id, logic [9:0] t);
      queue_word_t w;
      logic [11:0] slot;
      logic [9:0]  head_team;
      w.out_id = '0;
      if (c == CMD_ENQ) begin
        if (used_cnt + fresh_cnt < SLOT_CNT) begin
          slot     = free_top;
          free_top = slot_next[slot];
        end else if (fresh_cnt > 0) begin
          slot = 12'(SLOT_CNT - fresh_cnt);
          fresh_cnt--;
        end else begin
          w.status = STAT_FULL;
          return w;
        end
        used_cnt++;
        slot_id[slot]   = id;
        slot_next[slot] = '0;
        if (team_live[t]) begin
          slot_next[team_last[t]] = slot;
          team_last[t] = slot;
        end else begin
          team_live[t]  = 1'b1;
          team_first[t] = slot;
          team_last[t]  = slot;
          if (order_cnt < TEAM_CNT) begin
            team_order[order_wr] = t;
            order_wr++;
            order_cnt++;
          end
        end
        w.status = STAT_ENQ;
      end else begin
        if (order_cnt == 0) begin
          w.status = STAT_EMPTY;
          return w;
        end
        head_team = team_order[order_rd];
        slot      = team_first[head_team];
        w.out_id  = slot_id[slot];
        if (slot == team_last[head_team]) begin
          team_live[head_team] = 1'b0;
          order_rd++;
          order_cnt--;
        end else begin
          team_first[head_team] = slot_next[slot];
        end
        slot_next[slot] = free_top;
        free_top = slot;
        if (used_cnt > 0) used_cnt--;
        w.status = STAT_DEQ;
      end
      return w;
    endfunction

    function void note_command(logic c, logic [19:0] id, logic [9:0] t);
      expected_q.push_back(predict_word(c, id, t));
    endfunction

    function void check_word(logic [1:0] st, logic [19:0] oid);
      queue_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word status %0d out_id %05h", $time, st, oid);
        mismatches++;
        return;
      end
      w = expected_q.pop_front();
      if (st !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        mismatches++;
      end
      if (oid !== w.out_id) begin
        $display("%0t: out_id expected %05h actual %05h", $time, w.out_id, oid);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [19:0] element_id;
  logic [9:0]  team;
  logic        done;
  logic [1:0]  status;
  logic [19:0] out_id;

  team_queue_scoreboard sb;
  int sender_idle_pct;
  int stall_cycles;

  team_grouped_fifo_queue_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .element_id (element_id),
    .team       (team),
    .done       (done),
    .status     (status),
    .out_id     (out_id)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Check the finished word first: it belongs to an earlier command.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_word(status, out_id);
      if (start && !busy) sb.note_command(cmd, element_id, team);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input logic c, input logic [19:0] id, input logic [9:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    cmd        <= c;
    element_id <= id;
    team       <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic go_idle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Hold until every expected word has come back.
  task automatic wait_quiet();
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [9:0] pick_team();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 10'($urandom_range(7));
    if (r < 80) return 10'(TEAM_CNT - 1 - $urandom_range(3));
    return 10'($urandom_range(TEAM_CNT - 1));
  endfunction

  // Bursts with a varying enqueue share, so the queue both builds up and runs dry.
  task automatic run_random(input int count);
    int enq_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 30;
          1: enq_pct = 55;
          default: enq_pct = 75;
        endcase
      end
      send_word(($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                20'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sender_idle_pct = 0;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_ENQ;
    element_id = '0;
    team       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty dequeues, field extremes, grouping of teams.
    send_word(CMD_DEQ, 20'h00000, 10'h000);
    send_word(CMD_DEQ, 20'hFFFFF, 10'h3FF);
    send_word(CMD_ENQ, 20'h00000, 10'h000);
    send_word(CMD_ENQ, 20'hFFFFF, 10'h3FF);
    send_word(CMD_ENQ, 20'h12345, 10'h000);
    send_word(CMD_ENQ, 20'h55555, 10'h2AA);
    send_word(CMD_ENQ, 20'hAAAAA, 10'h155);
    send_word(CMD_ENQ, 20'h0F0F0, 10'h3FF);
    repeat (7) send_word(CMD_DEQ, 20'hFFFFF, 10'h3FF);
    send_word(CMD_ENQ, 20'h00001, 10'h005);
    send_word(CMD_DEQ, 20'h00000, 10'h000);
    send_word(CMD_ENQ, 20'h00002, 10'h005);
    send_word(CMD_ENQ, 20'h00003, 10'h006);
    send_word(CMD_ENQ, 20'h00004, 10'h005);
    repeat (4) send_word(CMD_DEQ, 20'h00000, 10'h000);

    sender_idle_pct = 36;
    for (int i = 0; i < 450; i++) send_word(pick_team() % 2 ? CMD_DEQ : CMD_ENQ,
                                            20'($urandom), pick_team());
    sender_idle_pct = 77;
    run_random(450);
    sender_idle_pct = 0;
    run_random(450);
    go_idle();

    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
